FILE: src/pmus_pkg.sv
// ----------------------------------------------------------------------------
// pmus_pkg
// Shared types and constants for the polarization mosaic unpacker.
// ----------------------------------------------------------------------------
package pmus_pkg;

  localparam int CFG_W          = 13;
  localparam int PIX_W          = 16;
  localparam int PLANE_POS_W    = 11;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd2448;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd2048;

  // configuration register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    FMT_MONO8       = 2'd0,
    FMT_MONO12_USB  = 2'd1,
    FMT_MONO12_GIGE = 2'd2,
    FMT_MONO16      = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    PH0 = 2'd0,
    PH1 = 2'd1,
    PH2 = 2'd2
  } phase_e;

  // rebuilt pixel from the unpacker
  typedef struct packed {
    logic             emit;
    logic [PIX_W-1:0] value;
  } pix_t;

  // plane tag for the pixel being emitted
  typedef struct packed {
    logic [1:0]             plane;
    logic [PLANE_POS_W-1:0] column;
    logic [PLANE_POS_W-1:0] row;
    logic                   last;
  } pos_t;

endpackage

FILE: src/pmus_cfg_regs.sv
// ----------------------------------------------------------------------------
// pmus_cfg_regs
// Format and frame size registers, with frame size clamped for use.
// ----------------------------------------------------------------------------
module pmus_cfg_regs
  import pmus_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int WW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1),
  localparam int HW = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [1:0]       index_i,
  input  logic [CFG_W-1:0] data_i,
  output fmt_e             fmt_o,
  output logic             fmt_wr_o,
  output logic [WW-1:0]    width_o,
  output logic [HW-1:0]    height_o
);

  typedef logic [WW-1:0] ww_t;
  typedef logic [HW-1:0] hw_t;

  fmt_e             fmt_q, fmt_d;
  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  ww_t              w_ext;
  hw_t              h_ext;

  always_comb begin
    fmt_d    = fmt_q;
    width_d  = width_q;
    height_d = height_q;
    fmt_wr_o = 1'b0;
    if (wr_i) begin
      unique case (index_i)
        REG_FORMAT: begin
          fmt_d    = fmt_e'(data_i[1:0]);
          fmt_wr_o = 1'b1;
        end
        REG_WIDTH:  width_d  = data_i;
        REG_HEIGHT: height_d = data_i;
        default: ;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_MONO8;
      width_q  <= RST_FRAME_WIDTH;
      height_q <= RST_FRAME_HEIGHT;
    end else begin
      fmt_q    <= fmt_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // clamp to 2..MAX
  always_comb begin
    w_ext = ww_t'(width_q);
    h_ext = hw_t'(height_q);
    if (w_ext < ww_t'(2))              width_o = ww_t'(2);
    else if (w_ext > ww_t'(MAX_WIDTH)) width_o = ww_t'(MAX_WIDTH);
    else                               width_o = w_ext;
    if (h_ext < hw_t'(2))               height_o = hw_t'(2);
    else if (h_ext > hw_t'(MAX_HEIGHT)) height_o = hw_t'(MAX_HEIGHT);
    else                                height_o = h_ext;
  end

  assign fmt_o = fmt_q;

endmodule

FILE: src/pmus_unpack.sv
// ----------------------------------------------------------------------------
// pmus_unpack
// Byte phase tracking and pixel rebuild for the four pixel formats.
// ----------------------------------------------------------------------------
module pmus_unpack
  import pmus_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  fmt_e       fmt_i,
  input  logic       fmt_wr_i,
  output pix_t       pix_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] h1_q, h1_d;
  logic [7:0] h2_q, h2_d;

  always_comb begin
    phase_d     = phase_q;
    h1_d        = h1_q;
    h2_d        = h2_q;
    pix_o.emit  = 1'b0;
    pix_o.value = '0;
    case (fmt_i)
      FMT_MONO8: begin
        phase_d     = PH0;
        pix_o.emit  = 1'b1;
        pix_o.value = {8'h00, byte_i};
      end
      FMT_MONO16: begin
        if (phase_q == PH0) begin
          h1_d    = byte_i;
          phase_d = PH1;
        end else begin
          phase_d     = PH0;
          pix_o.emit  = 1'b1;
          pix_o.value = {byte_i, h1_q};
        end
      end
      default: begin  // both 12-bit packed orders
        unique case (phase_q)
          PH0: begin
            h1_d    = byte_i;
            phase_d = PH1;
          end
          PH1: begin
            h2_d       = byte_i;
            phase_d    = PH2;
            pix_o.emit = 1'b1;
            if (fmt_i == FMT_MONO12_USB) pix_o.value = {byte_i[3:0], h1_q, 4'h0};
            else                         pix_o.value = {h1_q, byte_i[3:0], 4'h0};
          end
          default: begin
            phase_d     = PH0;
            pix_o.emit  = 1'b1;
            pix_o.value = {byte_i, h2_q[7:4], 4'h0};
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH0;
      h1_q    <= '0;
      h2_q    <= '0;
    end else if (fmt_wr_i) begin
      phase_q <= PH0;   // drop a partial pixel
    end else if (step_i) begin
      phase_q <= phase_d;
      h1_q    <= h1_d;
      h2_q    <= h2_d;
    end
  end

`ifndef SYNTH
  a_mono8_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fmt_i == FMT_MONO8) |-> (phase_q == PH0))
    else $error("mono8 with nonzero byte phase");
  a_mono16_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fmt_i == FMT_MONO16) |-> (phase_q != PH2))
    else $error("mono16 reached third byte phase");
`endif

endmodule

FILE: src/pmus_position.sv
// ----------------------------------------------------------------------------
// pmus_position
// Sensor column/row counters and polarization plane mapping.
// ----------------------------------------------------------------------------
module pmus_position
  import pmus_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int WW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1),
  localparam int HW = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [WW-1:0] width_i,
  input  logic [HW-1:0] height_i,
  output pos_t          pos_o
);

  localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CPW = (CW > PLANE_POS_W + 1) ? CW : PLANE_POS_W + 1;
  localparam int RPW = (RW > PLANE_POS_W + 1) ? RW : PLANE_POS_W + 1;

  typedef logic [WW:0]    wcmp_t;
  typedef logic [HW:0]    hcmp_t;
  typedef logic [CW-1:0]  col_t;
  typedef logic [RW-1:0]  row_t;
  typedef logic [CPW-1:0] cpad_t;
  typedef logic [RPW-1:0] rpad_t;

  col_t       col_q, col_d;
  row_t       row_q, row_d;
  logic       row_end;
  cpad_t      col_pad;
  rpad_t      row_pad;
  logic [1:0] plane;

  assign row_end    = (wcmp_t'(col_q) + wcmp_t'(1)) >= wcmp_t'(width_i);
  assign pos_o.last = row_end && ((hcmp_t'(row_q) + hcmp_t'(1)) >= hcmp_t'(height_i));

  assign col_pad      = cpad_t'(col_q);
  assign row_pad      = rpad_t'(row_q);
  assign pos_o.column = col_pad[PLANE_POS_W:1];
  assign pos_o.row    = row_pad[PLANE_POS_W:1];
  assign pos_o.plane  = plane;

  // even rows: even col -> 1, odd col -> 0; odd rows: even -> 2, odd -> 3
  always_comb begin
    case ({row_q[0], col_q[0]})
      2'b00:   plane = 2'd1;
      2'b01:   plane = 2'd0;
      2'b10:   plane = 2'd2;
      default: plane = 2'd3;
    endcase
  end

  always_comb begin
    col_d = col_q + col_t'(1);
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = pos_o.last ? '0 : row_q + row_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (step_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

`ifndef SYNTH
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && pos_o.last) |=> (col_q == '0 && row_q == '0))
    else $error("position did not wrap after last pixel");
`endif

endmodule

FILE: src/polar_mosaic_unpack_split_top.sv
// ----------------------------------------------------------------------------
// polar_mosaic_unpack_split_top
// Unpacks a camera byte stream into pixels tagged by polarization plane.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) moves one payload byte per word.
//   Output channel (out_valid_o/out_ready_i) moves one rebuilt pixel per word
//   with its plane index, plane column/row and a last-pixel-of-frame flag.
//   Bytes that only complete part of a pixel produce no output word.
//   Config channel (cfg_valid_i/cfg_ready_o) writes index 0 pixel format,
//   1 frame width, 2 frame height; always ready. Write only when idle.
//   Writing the format drops a partly received pixel.
// Timing:
//   Two-stage pipe: byte register, then result register. A pixel appears on
//   out_valid_o once the byte that completes it has passed both registers.
//   One byte per cycle while the receiver keeps up; the byte register can
//   take a byte while a result waits, so one more byte is taken in a stall.
//   When the receiver stalls both stages fill and in_ready_o drops.
// Reset:
//   rst_ni clears pipe valids, byte phase and counters, and loads mono8,
//   2448 x 2048.
// ----------------------------------------------------------------------------
module polar_mosaic_unpack_split_top
  import pmus_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // byte input
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  // pixel output
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PIX_W-1:0]       pixel_value_o,
  output logic [1:0]             plane_index_o,
  output logic [PLANE_POS_W-1:0] plane_column_o,
  output logic [PLANE_POS_W-1:0] plane_row_o,
  output logic                   frame_last_o,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  localparam int WW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
  localparam int HW = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1);

  // byte stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_adv;
  logic       in_fire;

  // result stage
  logic       out_valid_q, out_valid_d;
  pix_t       pix_q;
  pos_t       pos_q;

  fmt_e          fmt;
  logic          fmt_wr;
  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  pix_t          pix;
  pos_t          pos;

  assign cfg_ready_o = 1'b1;

  pmus_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .fmt_o   (fmt),
    .fmt_wr_o(fmt_wr),
    .width_o (width_eff),
    .height_o(height_eff)
  );

  // byte stage drains whenever the result register is free or being read
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  pmus_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .byte_i  (s1_byte_q),
    .fmt_i   (fmt),
    .fmt_wr_i(fmt_wr),
    .pix_o   (pix)
  );

  // counters move only on bytes that complete a pixel
  pmus_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv && pix.emit),
    .width_i (width_eff),
    .height_i(height_eff),
    .pos_o   (pos)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire)     s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (s1_adv)           out_valid_d = pix.emit;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) s1_byte_q <= data_byte_i;
    if (s1_adv && pix.emit) begin
      pix_q <= pix;
      pos_q <= pos;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = pix_q.value;
  assign plane_index_o  = pos_q.plane;
  assign plane_column_o = pos_q.column;
  assign plane_row_o    = pos_q.row;
  assign frame_last_o   = pos_q.last;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && s1_valid_q && !s1_adv))
    else $error("byte stage overwritten");
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && pix.emit) |=> out_valid_o)
    else $error("completed pixel not presented");
`endif

endmodule

FILE: tb/polar_mosaic_unpack_split_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_mosaic_unpack_split_top_tb
// Streams payload bytes through the unpacker in all four pixel formats and
// checks every pixel word (value, plane, plane position, last flag) against
// a cycle-free model of the unpacker kept in this bench. Both channels idle
// at random; register writes happen only while the block is drained.
// ----------------------------------------------------------------------------
module polar_mosaic_unpack_split_top_tb;
  import pmus_pkg::*;

  // index past the register list, the block must ignore it
  localparam logic [1:0] REG_SPARE = 2'd3;

  // plane codes by sensor row/column parity
  localparam logic [1:0] PLANE_EVROW_ODDCOL = 2'd0;
  localparam logic [1:0] PLANE_EVROW_EVCOL  = 2'd1;
  localparam logic [1:0] PLANE_ODROW_EVCOL  = 2'd2;
  localparam logic [1:0] PLANE_ODROW_ODDCOL = 2'd3;

  // pipe is two stages deep; wait a bit longer before touching registers
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_BYTES  = 1950;
  // receiver and sender do not idle at random while bytes taken lie in CALM_FROM..CALM_TO-1
  localparam int CALM_FROM     = 1000;
  localparam int CALM_TO       = 1400;

  // one entry of the byte stream plan: a payload byte or a register write
  typedef struct {
    bit               is_cfg;
    logic [1:0]       index;
    logic [CFG_W-1:0] data;
  } plan_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    pos_t             pos;
  } pixel_exp_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             data_byte_i = 8'h00;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [PIX_W-1:0]       pixel_value_o;
  logic [1:0]             plane_index_o;
  logic [PLANE_POS_W-1:0] plane_column_o;
  logic [PLANE_POS_W-1:0] plane_row_o;
  logic                   frame_last_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i = REG_FORMAT;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  plan_t      stream_plan_q[$];
  pixel_exp_t expected_pixels_q[$];
  int         pixels_in_flight = 0;
  int         quiet_cycles = 0;
  int         bytes_taken = 0;
  int         err_cnt = 0;
  logic       calm_q = 1'b0;

  // unpacker model state, reset values of the block
  fmt_e             cur_fmt = FMT_MONO8;
  logic [CFG_W-1:0] cur_width = RST_FRAME_WIDTH;
  logic [CFG_W-1:0] cur_height = RST_FRAME_HEIGHT;
  phase_e           pend_phase = PH0;
  logic [7:0]       lo_byte = 8'h00;
  logic [7:0]       mid_byte = 8'h00;
  logic [11:0]      sens_col = '0;
  logic [11:0]      sens_row = '0;

  polar_mosaic_unpack_split_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_o  (pixel_value_o),
    .plane_index_o  (plane_index_o),
    .plane_column_o (plane_column_o),
    .plane_row_o    (plane_row_o),
    .frame_last_o   (frame_last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Unpacker model
  // --------------------------------------------------------------------------
  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // tag a rebuilt pixel with its plane and position, then advance the raster
  task automatic tag_pixel(input logic [PIX_W-1:0] value);
    int unsigned w;
    int unsigned h;
    bit          row_end;
    bit          last;
    pixel_exp_t  px;
    w       = clamp_dim(cur_width, DEF_MAX_WIDTH);
    h       = clamp_dim(cur_height, DEF_MAX_HEIGHT);
    row_end = (int'(sens_col) + 1 >= w);
    last    = row_end && (int'(sens_row) + 1 >= h);
    px.value = value;
    if (!sens_row[0]) px.pos.plane = sens_col[0] ? PLANE_EVROW_ODDCOL : PLANE_EVROW_EVCOL;
    else px.pos.plane = sens_col[0] ? PLANE_ODROW_ODDCOL : PLANE_ODROW_EVCOL;
    px.pos.column = sens_col[11:1];
    px.pos.row    = sens_row[11:1];
    px.pos.last   = last;
    expected_pixels_q.push_back(px);
    pixels_in_flight++;
    if (row_end) begin
      sens_col = '0;
      sens_row = last ? 12'd0 : sens_row + 12'd1;
    end else begin
      sens_col = sens_col + 12'd1;
    end
  endtask

  task automatic unpack_byte(input logic [7:0] b);
    case (cur_fmt)
      FMT_MONO8: begin
        pend_phase = PH0;
        tag_pixel({8'h00, b});
      end
      FMT_MONO16: begin
        if (pend_phase == PH0) begin
          lo_byte    = b;
          pend_phase = PH1;
        end else begin
          pend_phase = PH0;
          tag_pixel({b, lo_byte});
        end
      end
      default: begin
        if (pend_phase == PH0) begin
          lo_byte    = b;
          pend_phase = PH1;
        end else if (pend_phase == PH1) begin
          mid_byte   = b;
          pend_phase = PH2;
          // first pixel of the group leaves on the middle byte
          if (cur_fmt == FMT_MONO12_USB) tag_pixel({b[3:0], lo_byte, 4'h0});
          else tag_pixel({lo_byte, b[3:0], 4'h0});
        end else begin
          pend_phase = PH0;
          tag_pixel({b, mid_byte[7:4], 4'h0});
        end
      end
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_FORMAT: begin
        cur_fmt    = fmt_e'(val[1:0]);
        pend_phase = PH0;  // a half-built pixel is dropped
      end
      REG_WIDTH:  cur_width = val;
      REG_HEIGHT: cur_height = val;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stream plan building
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b);
    plan_t p;
    p.is_cfg = 1'b0;
    p.index  = REG_FORMAT;
    p.data   = CFG_W'(b);
    stream_plan_q.push_back(p);
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    plan_t p;
    p.is_cfg = 1'b1;
    p.index  = idx;
    p.data   = val;
    stream_plan_q.push_back(p);
  endtask

  // mostly small even frames so frames wrap often; some odd, tiny and oversized
  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return CFG_W'($urandom_range(0, 1));
    else if (sel == 1) return CFG_W'($urandom_range(4097, 8191));
    else if (sel <= 4) return CFG_W'(2 * $urandom_range(1, 6) + 1);
    else return CFG_W'(2 * $urandom_range(1, 6));
  endfunction

  // --------------------------------------------------------------------------
  // Byte and register driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_proc
    plan_t nxt;
    logic  in_v;
    logic  cfg_v;
    bit    busy;
    if (rst_ni) begin
      in_v  = in_valid_i;
      cfg_v = cfg_valid_i;
      busy  = 1'b0;
      if (out_valid_o && out_ready_i) begin
        pixels_in_flight--;
        busy = 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        unpack_byte(data_byte_i);
        bytes_taken++;
        in_v = 1'b0;
        busy = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        write_reg(cfg_index_i, cfg_data_i);
        cfg_v = 1'b0;
        busy  = 1'b1;
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;

      if (!in_v && !cfg_v && stream_plan_q.size() != 0) begin
        nxt = stream_plan_q[0];
        if (nxt.is_cfg) begin
          // registers only move once the pipe has drained
          if (pixels_in_flight == 0 && quiet_cycles >= SETTLE_CYCLES) begin
            cfg_v       = 1'b1;
            cfg_index_i <= nxt.index;
            cfg_data_i  <= nxt.data;
            void'(stream_plan_q.pop_front());
          end
        end else if (calm_q || $urandom_range(0, 99) >= 25) begin
          in_v        = 1'b1;
          data_byte_i <= nxt.data[7:0];
          void'(stream_plan_q.pop_front());
        end
      end
      in_valid_i  <= in_v;
      cfg_valid_i <= cfg_v;
      calm_q      <= (bytes_taken >= CALM_FROM) && (bytes_taken < CALM_TO);
    end
  end

  // --------------------------------------------------------------------------
  // Pixel monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_proc
    pixel_exp_t px;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels_q.size() == 0) begin
          $error("unexpected pixel word: value %h plane %0d col %0d row %0d last %0b",
                 pixel_value_o, plane_index_o, plane_column_o, plane_row_o, frame_last_o);
          err_cnt++;
        end else begin
          px = expected_pixels_q.pop_front();
          if (pixel_value_o !== px.value) begin
            $error("pixel_value: expected %h, actual %h", px.value, pixel_value_o);
            err_cnt++;
          end
          if (plane_index_o !== px.pos.plane) begin
            $error("plane_index: expected %0d, actual %0d", px.pos.plane, plane_index_o);
            err_cnt++;
          end
          if (plane_column_o !== px.pos.column) begin
            $error("plane_column: expected %0d, actual %0d", px.pos.column, plane_column_o);
            err_cnt++;
          end
          if (plane_row_o !== px.pos.row) begin
            $error("plane_row: expected %0d, actual %0d", px.pos.row, plane_row_o);
            err_cnt++;
          end
          if (frame_last_o !== px.pos.last) begin
            $error("frame_last: expected %0b, actual %0b", px.pos.last, frame_last_o);
            err_cnt++;
          end
        end
      end
      out_ready_i <= calm_q || ($urandom_range(0, 99) >= 25);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : run_proc
    int rand_bytes;
    int n;
    rand_bytes = 0;

    // reset dims and mono8, byte extremes
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h55);
    add_byte(8'hAA);
    // smallest frame, Mono12p: one whole 2x2 frame with last flag
    add_cfg(REG_WIDTH, CFG_W'(2));
    add_cfg(REG_HEIGHT, CFG_W'(2));
    add_cfg(REG_FORMAT, CFG_W'(FMT_MONO12_USB));
    add_byte(8'hFF); add_byte(8'h0F); add_byte(8'hF0);
    add_byte(8'h00); add_byte(8'hFF); add_byte(8'h00);
    // Mono12Packed, second pixel takes the high nibble of the middle byte
    add_cfg(REG_FORMAT, CFG_W'(FMT_MONO12_GIGE));
    add_byte(8'h12); add_byte(8'h34); add_byte(8'h56);
    add_byte(8'hFF); add_byte(8'hF0); add_byte(8'h0F);
    // mono16 little endian
    add_cfg(REG_FORMAT, CFG_W'(FMT_MONO16));
    add_byte(8'h00); add_byte(8'hFF);
    add_byte(8'hFF); add_byte(8'h00);
    // half a group, then a format write drops it
    add_cfg(REG_FORMAT, CFG_W'(FMT_MONO12_USB));
    add_byte(8'hAB);
    add_cfg(REG_FORMAT, CFG_W'(FMT_MONO12_GIGE));
    add_byte(8'hC3); add_byte(8'h5A); add_byte(8'h3C);
    // write past the register list
    add_cfg(REG_SPARE, CFG_W'(13'h1FFF));

    // widest frame via clamping and tallest frame, mono8
    add_cfg(REG_WIDTH, CFG_W'(8191));
    add_cfg(REG_HEIGHT, CFG_W'(DEF_MAX_HEIGHT));
    add_cfg(REG_FORMAT, CFG_W'(FMT_MONO8));
    repeat (500) add_byte(8'($urandom_range(0, 255)));
    rand_bytes += 500;
    // undersized dims clamp up to 2
    add_cfg(REG_WIDTH, CFG_W'(0));
    add_cfg(REG_HEIGHT, CFG_W'(1));
    repeat (40) add_byte(8'($urandom_range(0, 255)));
    rand_bytes += 40;

    // random phases; sizes change mid-frame and partial pixels get cut
    while (rand_bytes < RANDOM_BYTES) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9)) inside
          0:       add_cfg(REG_SPARE, CFG_W'($urandom_range(0, 8191)));
          [1:3]:   add_cfg(REG_FORMAT, CFG_W'($urandom_range(0, 8191)));
          [4:6]:   add_cfg(REG_WIDTH, pick_dim());
          default: add_cfg(REG_HEIGHT, pick_dim());
        endcase
      end
      n = $urandom_range(10, 120);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
      rand_bytes += n;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (stream_plan_q.size() != 0 || in_valid_i || cfg_valid_i || pixels_in_flight != 0);
    repeat (20) @(negedge clk_i);

    if (expected_pixels_q.size() != 0) begin
      $error("%0d expected pixel words never arrived", expected_pixels_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : limit_proc
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
